[rtl/assert_macros.svh]
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/tfc_pkg.sv]
package tfc_pkg;

    localparam int SRC_COLS   = 32;
    localparam int LINE_WORDS = 2 * SRC_COLS;

    localparam int TEMP_W  = 16;
    localparam int CFG_W   = 14;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int ADDR_W  = 12;
    localparam int COLOR_W = 16;

    localparam logic signed [TEMP_W-1:0] MIN_START = 16'sd4800;
    localparam logic signed [TEMP_W-1:0] MAX_START = -16'sd640;

    localparam logic signed [CFG_W-1:0] COLOR_LOW_RESET  = 14'sd432;
    localparam logic signed [CFG_W-1:0] COLOR_HIGH_RESET = 14'sd544;

    // normalized value n has 12 fraction bits, range 0..4096
    localparam int NORM_FRAC_W = 12;
    localparam int NORM_W      = NORM_FRAC_W + 1;
    localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1 << NORM_FRAC_W);
    localparam int MAG_W       = 14;
    localparam int DIFF_W      = TEMP_W + 1;
    localparam int DEN_W       = CFG_W + 1;

    localparam int DIV_BITS_PER_CYCLE = 3;
    localparam int DIV_CYCLES = NORM_FRAC_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam int BEAT_W = 3;
    localparam logic [BEAT_W-1:0] BEAT_LAST_WRITE = 3'd3;
    localparam logic [BEAT_W-1:0] BEAT_STATS      = 3'd4;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_STATS = 1'b1;

    // colormap segment boundaries in 1/4096 units
    localparam logic [NORM_W-1:0] SEG_A = 13'd512;
    localparam logic [NORM_W-1:0] SEG_B = 13'd1536;
    localparam logic [NORM_W-1:0] SEG_C = 13'd2560;
    localparam logic [NORM_W-1:0] SEG_D = 13'd3584;

    typedef enum logic [0:0] {
        REG_COLOR_LOW  = 1'b0,
        REG_COLOR_HIGH = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        NC_ZERO,
        NC_FULL,
        NC_DIVIDE
    } norm_class_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_MAP,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [ROW_W-1:0]         src_row;
        logic [COL_W-1:0]         src_col;
        logic                     frame_end;
    } tfc_in_t;

    typedef struct packed {
        logic                     kind;
        logic [ADDR_W-1:0]        address;
        logic [COLOR_W-1:0]       color;
        logic signed [TEMP_W-1:0] frame_min;
        logic signed [TEMP_W-1:0] frame_max;
        logic                     last;
    } tfc_out_t;

    typedef struct packed {
        norm_class_t              nclass;
        logic [MAG_W-1:0]         num_mag;
        logic [MAG_W-1:0]         den_mag;
        logic [ROW_W-1:0]         src_row;
        logic [COL_W-1:0]         src_col;
        logic                     frame_end;
        logic signed [TEMP_W-1:0] frame_min;
        logic signed [TEMP_W-1:0] frame_max;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [COLOR_W-1:0] jet565(input logic [NORM_W-1:0] n);
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        logic [NORM_W-1:0] m;
        logic [20:0]       p;
        logic [20:0]       p2;
        r  = '0;
        g  = '0;
        b  = '0;
        m  = '0;
        p  = '0;
        p2 = '0;
        if (n < SEG_A) begin
            p = 21'(n) * 21'd127;
            b = 8'd128 + 8'(p >> 9);
        end else if (n < SEG_B) begin
            m = n - SEG_A;
            p = 21'(m) * 21'd255;
            g = 8'(p >> 10);
            b = 8'd255;
        end else if (n < SEG_C) begin
            m  = n - SEG_B;
            p  = 21'(m) * 21'd255;
            p2 = 21'(SEG_C - n) * 21'd255;
            r  = 8'(p >> 10);
            g  = 8'd255;
            b  = 8'(p2 >> 10);
        end else if (n < SEG_D) begin
            p = 21'(SEG_D - n) * 21'd255;
            r = 8'd255;
            g = 8'(p >> 10);
        end else begin
            m = n - SEG_D;
            p = 21'd130560 - 21'(m) * 21'd128;
            r = 8'(p >> 9);
        end
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

[rtl/thermal_frame_colorizer.sv]
// Thermal pixel colorizer. Each input beat is one sensor pixel; it yields four
// framebuffer write beats (a mirrored 2x2 block, address order dy,dx = 00, 01,
// 10, 11) colored with the jet map in RGB565, plus a statistics beat carrying
// the frame's min and max temperature after a pixel marked frame_end. The
// front end classifies the pixel against the color window and tracks min/max,
// then hands it through a two-entry queue to the back end. The back end owns
// the normalizing divider (3 quotient bits per cycle), a colormap step and the
// output register, and takes one pixel at a time: it loads the pixel, divides,
// maps the color and emits the four writes, then the statistics beat if any;
// a value that clamps skips the division, and output stalls hold the writes.
// Write color_low and color_high only while no pixel is in flight.
module thermal_frame_colorizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tfc_pkg::tfc_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tfc_pkg::tfc_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [0:0]                          cfg_index,
    input  logic [tfc_pkg::CFG_W-1:0]           cfg_data
);

    logic signed [tfc_pkg::CFG_W-1:0] color_low_reg, color_low_next;
    logic signed [tfc_pkg::CFG_W-1:0] color_high_reg, color_high_next;

    tfc_pkg::q_status_t q_status;
    tfc_pkg::q_entry_t  push_data;
    tfc_pkg::q_entry_t  pop_data;
    logic               push;
    logic               pop;

    always_comb begin
        color_low_next  = color_low_reg;
        color_high_next = color_high_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                tfc_pkg::REG_COLOR_LOW:  color_low_next  = cfg_data;
                tfc_pkg::REG_COLOR_HIGH: color_high_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_low_reg  <= tfc_pkg::COLOR_LOW_RESET;
            color_high_reg <= tfc_pkg::COLOR_HIGH_RESET;
        end else begin
            color_low_reg  <= color_low_next;
            color_high_reg <= color_high_next;
        end
    end

    tfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .color_low  (color_low_reg),
        .color_high (color_high_reg),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    tfc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    tfc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[rtl/tfc_front.sv]
module tfc_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  tfc_pkg::tfc_in_t                      s_data,
    input  logic signed [tfc_pkg::CFG_W-1:0]      color_low,
    input  logic signed [tfc_pkg::CFG_W-1:0]      color_high,
    input  tfc_pkg::q_status_t                    q_status,
    output logic                                  push,
    output tfc_pkg::q_entry_t                     push_data
);

    logic signed [tfc_pkg::TEMP_W-1:0] running_min_reg, running_min_next;
    logic signed [tfc_pkg::TEMP_W-1:0] running_max_reg, running_max_next;

    logic signed [tfc_pkg::DIFF_W-1:0] diff;
    logic signed [tfc_pkg::DEN_W-1:0]  den;
    logic [tfc_pkg::DIFF_W-2:0]        diff_mag;
    logic [tfc_pkg::MAG_W-1:0]         den_mag;
    logic signed [tfc_pkg::TEMP_W-1:0] min_now;
    logic signed [tfc_pkg::TEMP_W-1:0] max_now;
    tfc_pkg::norm_class_t              nclass;

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        diff = {s_data.temperature[tfc_pkg::TEMP_W-1], s_data.temperature}
             - {{(tfc_pkg::DIFF_W-tfc_pkg::CFG_W){color_low[tfc_pkg::CFG_W-1]}}, color_low};
        den  = {color_high[tfc_pkg::CFG_W-1], color_high}
             - {color_low[tfc_pkg::CFG_W-1], color_low};
        diff_mag = diff[tfc_pkg::DIFF_W-1] ? (tfc_pkg::DIFF_W-1)'(-diff)
                                           : (tfc_pkg::DIFF_W-1)'(diff);
        den_mag  = den[tfc_pkg::DEN_W-1] ? tfc_pkg::MAG_W'(-den) : tfc_pkg::MAG_W'(den);

        // quotient sign follows the operand signs; a zero or negative result clamps to 0
        if (den == '0) begin
            nclass = (!diff[tfc_pkg::DIFF_W-1] && diff != '0) ? tfc_pkg::NC_FULL
                                                              : tfc_pkg::NC_ZERO;
        end else if (diff == '0 || diff[tfc_pkg::DIFF_W-1] != den[tfc_pkg::DEN_W-1]) begin
            nclass = tfc_pkg::NC_ZERO;
        end else if (diff_mag >= (tfc_pkg::DIFF_W-1)'(den_mag)) begin
            nclass = tfc_pkg::NC_FULL;
        end else begin
            nclass = tfc_pkg::NC_DIVIDE;
        end

        min_now = (s_data.temperature < running_min_reg) ? s_data.temperature
                                                         : running_min_reg;
        max_now = (s_data.temperature > running_max_reg) ? s_data.temperature
                                                         : running_max_reg;

        push_data.nclass    = nclass;
        push_data.num_mag   = tfc_pkg::MAG_W'(diff_mag);
        push_data.den_mag   = den_mag;
        push_data.src_row   = s_data.src_row;
        push_data.src_col   = s_data.src_col;
        push_data.frame_end = s_data.frame_end;
        push_data.frame_min = min_now;
        push_data.frame_max = max_now;

        running_min_next = running_min_reg;
        running_max_next = running_max_reg;
        if (push) begin
            if (s_data.frame_end) begin
                running_min_next = tfc_pkg::MIN_START;
                running_max_next = tfc_pkg::MAX_START;
            end else begin
                running_min_next = min_now;
                running_max_next = max_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_min_reg <= tfc_pkg::MIN_START;
            running_max_reg <= tfc_pkg::MAX_START;
        end else begin
            running_min_reg <= running_min_next;
            running_max_reg <= running_max_next;
        end
    end

endmodule

[rtl/tfc_queue.sv]
module tfc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tfc_pkg::q_entry_t   push_data,
    input  logic                pop,
    output tfc_pkg::q_entry_t   pop_data,
    output tfc_pkg::q_status_t  q_status
);

    tfc_pkg::q_entry_t           entry_reg [tfc_pkg::Q_DEPTH];
    logic [tfc_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tfc_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tfc_pkg::Q_PTR_W:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == (tfc_pkg::Q_PTR_W+1)'(tfc_pkg::Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_data       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == tfc_pkg::Q_PTR_W'(tfc_pkg::Q_DEPTH-1)) ? '0
                                                                                : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == tfc_pkg::Q_PTR_W'(tfc_pkg::Q_DEPTH-1)) ? '0
                                                                                : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/tfc_back.sv]
module tfc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tfc_pkg::q_status_t  q_status,
    input  tfc_pkg::q_entry_t   pop_data,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output tfc_pkg::tfc_out_t   m_data
);

    tfc_pkg::back_state_t            state_reg, state_next;
    tfc_pkg::q_entry_t               ent_reg, ent_next;
    logic [tfc_pkg::MAG_W-1:0]       rem_reg, rem_next;
    logic [tfc_pkg::NORM_FRAC_W-1:0] quo_reg, quo_next;
    logic [tfc_pkg::DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [tfc_pkg::NORM_W-1:0]      n_reg, n_next;
    logic [tfc_pkg::COLOR_W-1:0]     color_reg, color_next;
    logic [tfc_pkg::BEAT_W-1:0]      beat_reg, beat_next;
    logic                            m_valid_reg, m_valid_next;
    tfc_pkg::tfc_out_t               m_data_reg, m_data_next;

    logic [tfc_pkg::MAG_W-1:0]       step_rem;
    logic [tfc_pkg::NORM_FRAC_W-1:0] step_quo;
    tfc_pkg::tfc_out_t               beat_out;
    logic                            beat_final;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // restoring division, DIV_BITS_PER_CYCLE quotient bits per cycle; remainder stays below divisor
    always_comb begin
        logic [tfc_pkg::MAG_W:0] r2;
        step_rem = rem_reg;
        step_quo = quo_reg;
        for (int i = 0; i < tfc_pkg::DIV_BITS_PER_CYCLE; i++) begin
            r2 = {step_rem, 1'b0};
            if (r2 >= {1'b0, ent_reg.den_mag}) begin
                r2       = r2 - {1'b0, ent_reg.den_mag};
                step_quo = {step_quo[tfc_pkg::NORM_FRAC_W-2:0], 1'b1};
            end else begin
                step_quo = {step_quo[tfc_pkg::NORM_FRAC_W-2:0], 1'b0};
            end
            step_rem = r2[tfc_pkg::MAG_W-1:0];
        end
    end

    // beat order: (dy,dx) = 00, 01, 10, 11, then statistics on frame end
    always_comb begin
        beat_out = '0;
        if (beat_reg == tfc_pkg::BEAT_STATS) begin
            beat_out.kind      = tfc_pkg::KIND_STATS;
            beat_out.frame_min = ent_reg.frame_min;
            beat_out.frame_max = ent_reg.frame_max;
            beat_out.last      = 1'b1;
        end else begin
            beat_out.kind    = tfc_pkg::KIND_WRITE;
            beat_out.address = ({6'b0, ent_reg.src_row, 1'b0} + {11'b0, beat_reg[1]})
                             * tfc_pkg::ADDR_W'(tfc_pkg::LINE_WORDS)
                             + tfc_pkg::ADDR_W'(2 * (tfc_pkg::SRC_COLS - 1))
                             - {6'b0, ent_reg.src_col, 1'b0}
                             + {11'b0, beat_reg[0]};
            beat_out.color   = color_reg;
            beat_out.last    = (beat_reg == tfc_pkg::BEAT_LAST_WRITE) && !ent_reg.frame_end;
        end
        beat_final = (beat_reg == tfc_pkg::BEAT_STATS)
                  || ((beat_reg == tfc_pkg::BEAT_LAST_WRITE) && !ent_reg.frame_end);
    end

    always_comb begin
        state_next   = state_reg;
        ent_next     = ent_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        div_cnt_next = div_cnt_reg;
        n_next       = n_reg;
        color_next   = color_reg;
        beat_next    = beat_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pop          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            tfc_pkg::BK_IDLE: begin
                if (!q_status.empty) begin
                    pop          = 1'b1;
                    ent_next     = pop_data;
                    rem_next     = pop_data.num_mag;
                    quo_next     = '0;
                    div_cnt_next = '0;
                    unique case (pop_data.nclass)
                        tfc_pkg::NC_DIVIDE: begin
                            state_next = tfc_pkg::BK_DIV;
                        end
                        tfc_pkg::NC_FULL: begin
                            n_next     = tfc_pkg::NORM_ONE;
                            state_next = tfc_pkg::BK_MAP;
                        end
                        default: begin
                            n_next     = '0;
                            state_next = tfc_pkg::BK_MAP;
                        end
                    endcase
                end
            end
            tfc_pkg::BK_DIV: begin
                rem_next     = step_rem;
                quo_next     = step_quo;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == tfc_pkg::DIV_CNT_W'(tfc_pkg::DIV_CYCLES - 1)) begin
                    n_next     = {1'b0, step_quo};
                    state_next = tfc_pkg::BK_MAP;
                end
            end
            tfc_pkg::BK_MAP: begin
                color_next = tfc_pkg::jet565(n_reg);
                beat_next  = '0;
                state_next = tfc_pkg::BK_EMIT;
            end
            tfc_pkg::BK_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = beat_out;
                    beat_next    = beat_reg + 1'b1;
                    if (beat_final) begin
                        state_next = tfc_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = tfc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tfc_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg     <= ent_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        n_reg       <= n_next;
        color_reg   <= color_next;
        beat_reg    <= beat_next;
        m_data_reg  <= m_data_next;
    end

endmodule

[rtl/tfc_checker.sv]
`include "assert_macros.svh"

module tfc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input tfc_pkg::tfc_out_t m_data
);

    `ASSERT_NEXT(a_out_valid_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_out_data_holds, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
    // statistics beat always closes a pixel's results
    `ASSERT_IMPLY(a_stats_last, aclk, aresetn, m_valid && m_data.kind, m_data.last)
    `ASSERT_IMPLY(a_stats_clean, aclk, aresetn, m_valid && m_data.kind, m_data.address == '0 && m_data.color == '0)
    `ASSERT_IMPLY(a_write_clean, aclk, aresetn, m_valid && !m_data.kind, m_data.frame_min == '0 && m_data.frame_max == '0)

endmodule

bind thermal_frame_colorizer tfc_checker u_tfc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/thermal_frame_colorizer_tb.sv]
module thermal_frame_colorizer_tb;
    import tfc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_PAUSE = 16;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    tfc_in_t         s_data;
    logic            m_valid;
    logic            m_ready;
    tfc_out_t        m_data;
    logic            cfg_wr_en;
    logic [0:0]      cfg_index;
    logic [CFG_W-1:0] cfg_data;

    thermal_frame_colorizer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // colorizer state as the testbench sees it
    int win_lo;
    int win_hi;
    int frame_lo;
    int frame_hi;

    tfc_out_t pending_beats[$];

    int fail_count;
    int cycle_count;
    int pixels_sent;
    int frames_closed;
    int beats_checked;
    int windows_used;
    bit idle_on;
    int hold_left;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d beats outstanding",
                         cycle_count, pending_beats.size());
                $display("thermal_frame_colorizer_tb: FAIL");
                $finish;
            end
        end
    end

    // ---------------- prediction ----------------

    function automatic int norm_level(int t, int lo, int hi);
        longint num;
        longint den;
        longint q;
        num = longint'(t - lo) * 4096;
        den = longint'(hi - lo);
        if (den == 0)
            return (t > lo) ? 4096 : 0;
        q = num / den;
        if (q < 0)
            q = 0;
        if (q > 4096)
            q = 4096;
        return int'(q);
    endfunction

    function automatic logic [COLOR_W-1:0] jet_rgb565(int n);
        int r;
        int g;
        int b;
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        r = 0;
        g = 0;
        b = 0;
        if (n < 512) begin
            b = 128 + (127 * n) / 512;
        end else if (n < 1536) begin
            g = (255 * (n - 512)) / 1024;
            b = 255;
        end else if (n < 2560) begin
            r = (255 * (n - 1536)) / 1024;
            g = 255;
            b = (255 * (2560 - n)) / 1024;
        end else if (n < 3584) begin
            r = 255;
            g = (255 * (3584 - n)) / 1024;
        end else begin
            r = (255 * 512 - 128 * (n - 3584)) / 512;
        end
        r8 = 8'(r);
        g8 = 8'(g);
        b8 = 8'(b);
        return {r8[7:3], g8[7:2], b8[7:3]};
    endfunction

    task automatic colorize_pixel(input tfc_in_t px);
        int t;
        int base;
        int a;
        logic [COLOR_W-1:0] rgb;
        tfc_out_t beat;
        t   = int'($signed(px.temperature));
        rgb = jet_rgb565(norm_level(t, win_lo, win_hi));
        if (t < frame_lo)
            frame_lo = t;
        if (t > frame_hi)
            frame_hi = t;
        base = 2 * (SRC_COLS - 1 - int'(px.src_col));
        for (int k = 0; k < 4; k++) begin
            a = (2 * int'(px.src_row) + k / 2) * LINE_WORDS + base + k % 2;
            beat = '0;
            beat.kind    = KIND_WRITE;
            beat.address = ADDR_W'(a);
            beat.color   = rgb;
            beat.last    = (k == 3) && !px.frame_end;
            pending_beats.push_back(beat);
        end
        if (px.frame_end) begin
            beat = '0;
            beat.kind      = KIND_STATS;
            beat.frame_min = TEMP_W'(frame_lo);
            beat.frame_max = TEMP_W'(frame_hi);
            beat.last      = 1'b1;
            pending_beats.push_back(beat);
            frame_lo = int'(MIN_START);
            frame_hi = int'(MAX_START);
            frames_closed++;
        end
    endtask

    // ---------------- checking ----------------

    task automatic note_failure(input string what, input tfc_out_t want, input tfc_out_t got);
        fail_count++;
        if (fail_count <= 10)
            $display({"%s: want kind=%0d addr=%0d color=%h min=%0d max=%0d last=%0d",
                      " | got kind=%0d addr=%0d color=%h min=%0d max=%0d last=%0d"},
                     what, want.kind, want.address, want.color, want.frame_min,
                     want.frame_max, want.last, got.kind, got.address, got.color,
                     got.frame_min, got.frame_max, got.last);
    endtask

    initial begin
        tfc_out_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_beats.size() == 0) begin
                    note_failure("unexpected beat", '0, m_data);
                end else begin
                    want = pending_beats.pop_front();
                    beats_checked++;
                    if (m_data !== want)
                        note_failure("beat mismatch", want, m_data);
                end
            end
        end
    end

    // result side: random stall bursts, quiet stretches, and a long hold on request
    initial begin
        int  stall_left;
        int  quiet_left;
        logic rdy;
        stall_left = 0;
        quiet_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                rdy = 1'b0;
                stall_left--;
            end else if (quiet_left > 0) begin
                rdy = 1'b1;
                quiet_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                rdy = 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                rdy = 1'b1;
                if ($urandom_range(0, 15) == 0)
                    quiet_left = $urandom_range(10, 40);
            end
            m_ready <= rdy;
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic tfc_in_t make_pixel(int t, int row, int col, bit fe);
        tfc_in_t px;
        px.temperature = TEMP_W'(t);
        px.src_row     = ROW_W'(row);
        px.src_col     = COL_W'(col);
        px.frame_end   = fe;
        return px;
    endfunction

    task automatic send_pixel(input tfc_in_t px);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        colorize_pixel(px);
        pixels_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (pending_beats.size() != 0)
            @(posedge aclk);
        // a quiet pause before the window changes
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic set_window(input int lo, input int hi);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_COLOR_LOW;
        cfg_data  <= CFG_W'(lo);
        @(negedge aclk);
        cfg_index <= REG_COLOR_HIGH;
        cfg_data  <= CFG_W'(hi);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        win_lo = lo;
        win_hi = hi;
        windows_used++;
    endtask

    function automatic int pick_temperature();
        int lo;
        int hi;
        lo = (win_lo < win_hi) ? win_lo : win_hi;
        hi = (win_lo < win_hi) ? win_hi : win_lo;
        case ($urandom_range(0, 5))
            0: return int'($signed(16'($urandom())));
            1: return lo - 8 + int'($urandom_range(0, 16));
            2: return hi - 8 + int'($urandom_range(0, 16));
            3: return int'(MIN_START) - 4 + int'($urandom_range(0, 8));
            default: return lo - 16 + int'($urandom_range(0, hi - lo + 32));
        endcase
    endfunction

    function automatic int pick_cfg();
        return int'($urandom_range(0, 9215)) - 1024;
    endfunction

    task automatic send_frames(input int count);
        int left;
        int len;
        bit fe;
        left = count;
        while (left > 0) begin
            len = $urandom_range(1, 7);
            for (int i = 0; i < len && left > 0; i++) begin
                fe = (i == len - 1);
                // a few broken frames: early end marks or missing ones
                if ($urandom_range(0, 19) == 0)
                    fe = ~fe;
                send_pixel(make_pixel(pick_temperature(), $urandom_range(0, 31),
                                      $urandom_range(0, 31), fe));
                left--;
            end
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_window();
        send_pixel(make_pixel(432, 0, 0, 1'b0));
        send_pixel(make_pixel(544, 31, 31, 1'b0));
        send_pixel(make_pixel(488, 23, 0, 1'b0));
        send_pixel(make_pixel(-32768, 0, 31, 1'b0));
        send_pixel(make_pixel(32767, 31, 0, 1'b1));
    endtask

    task automatic test_colormap_segments();
        int n_points[11] = '{0, 511, 512, 1535, 1536, 2559, 2560, 3583, 3584, 4095, 4096};
        // with this window n equals the temperature
        set_window(0, 4096);
        foreach (n_points[i])
            send_pixel(make_pixel(n_points[i], i, 30 - i, i == 10));
    endtask

    task automatic test_special_windows();
        set_window(100, 100);
        send_pixel(make_pixel(99, 1, 2, 1'b0));
        send_pixel(make_pixel(100, 2, 3, 1'b0));
        send_pixel(make_pixel(101, 3, 4, 1'b1));
        set_window(8191, -1024);
        send_pixel(make_pixel(-1024, 4, 5, 1'b0));
        send_pixel(make_pixel(8191, 5, 6, 1'b0));
        send_pixel(make_pixel(3000, 6, 7, 1'b1));
        // frames that never move the start values on one side
        send_pixel(make_pixel(5000, 7, 8, 1'b1));
        send_pixel(make_pixel(-1000, 8, 9, 1'b1));
    endtask

    task automatic test_random_frames();
        int lo;
        int hi;
        set_window(-1024, 8191);
        send_frames(20);
        set_window(8191, -1024);
        send_frames(15);
        for (int ph = 0; ph < 5; ph++) begin
            lo = pick_cfg();
            case ($urandom_range(0, 3))
                0: hi = lo;
                1: hi = pick_cfg();
                default: hi = lo + $urandom_range(1, 600);
            endcase
            if (hi > 8191)
                hi = 8191;
            set_window(lo, hi);
            send_frames(12);
        end
    endtask

    task automatic test_backpressure();
        set_window(-200, 900);
        @(posedge aclk);
        hold_left = 80;
        for (int i = 0; i < 12; i++)
            send_pixel(make_pixel(pick_temperature(), $urandom_range(0, 31),
                                  $urandom_range(0, 31), i == 11));
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        set_window(432, 544);
        send_frames(25);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_COLOR_LOW;
        cfg_data  = '0;
        hold_left = 0;
        idle_on   = 1'b1;
        fail_count    = 0;
        pixels_sent   = 0;
        frames_closed = 0;
        beats_checked = 0;
        windows_used  = 1;
        win_lo   = int'(COLOR_LOW_RESET);
        win_hi   = int'(COLOR_HIGH_RESET);
        frame_lo = int'(MIN_START);
        frame_hi = int'(MAX_START);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_window();
        test_colormap_segments();
        test_special_windows();
        test_random_frames();
        test_backpressure();
        test_full_rate();

        drain();
        $display("%0d pixels in %0d frames, %0d beats checked, %0d color windows",
                 pixels_sent, frames_closed, beats_checked, windows_used);
        $display("covered colormap segment edges, empty and inverted windows, back-pressure");
        if (fail_count == 0) begin
            $display("thermal_frame_colorizer_tb: PASS");
        end else begin
            $display("%0d failures", fail_count);
            $display("thermal_frame_colorizer_tb: FAIL");
        end
        $finish;
    end

endmodule
